// ----- hdl/salsa20_keystream_cipher_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Salsa20 keystream cipher unit: assertion macros
// Shared assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SALSA20_KEYSTREAM_CIPHER_UNIT_DEFINES_SVH
`define SALSA20_KEYSTREAM_CIPHER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SKS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sks assertion failed");
`define SKS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sks assertion failed");
`else
`define SKS_ASSERT_IMP(lbl, ante, cons)
`define SKS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/sks_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Salsa20 keystream cipher package
// Constants, round schedule and types shared by the cipher unit.
// ---------------------------------------------------------------------------
package sks_pkg;

  typedef logic [31:0] word_t;
  typedef word_t word16_t [16];
  typedef word_t word8_t [8];

  typedef enum logic [1:0] {
    ST_RUN,
    ST_ROUND,
    ST_FEED
  } sks_state_t;

  localparam int unsigned DoubleRounds = 10;
  localparam logic [4:0] LAST_ROUND = 5'(2 * DoubleRounds - 1);

  localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};
  localparam word_t TAU [4]   = '{32'h61707865, 32'h3120646e, 32'h79622d36, 32'h6b206574};

  // Word indexes (a, b, c, d) of the four quarter rounds: column round, then row round.
  localparam logic [3:0] QIDX [2][4][4] = '{
    '{'{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
      '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11}},
    '{'{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
      '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14}}
  };

  // Rotation of each of the four quarter-round steps: 7, 9, 13, 18.
  function automatic word_t qr_rot(input word_t v, input logic [1:0] step);
    word_t r;
    unique case (step)
      2'd0: r = {v[24:0], v[31:25]};
      2'd1: r = {v[22:0], v[31:23]};
      2'd2: r = {v[18:0], v[31:19]};
      default: r = {v[13:0], v[31:14]};
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/sks_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Salsa20 input channel
// Valid/ready channel carrying one data or restart item per beat.
// ---------------------------------------------------------------------------
interface sks_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       long_key;
  logic       extended_nonce;

  modport source (output valid, action, data_byte, long_key, extended_nonce, input ready);
  modport sink (input valid, action, data_byte, long_key, extended_nonce, output ready);
endinterface

// ----- hdl/sks_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Salsa20 output channel
// Valid/ready channel carrying one enciphered byte per beat.
// ---------------------------------------------------------------------------
interface sks_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, out_byte, input ready);
  modport sink (input valid, out_byte, output ready);
endinterface

// ----- hdl/sks_cfg_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Salsa20 configuration channel
// Register write channel: index and 64-bit data per beat.
// ---------------------------------------------------------------------------
interface sks_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/salsa20_keystream_cipher_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Salsa20 keystream cipher unit
// Salsa20/20 byte stream cipher with optional XSalsa20 key derivation.
// ---------------------------------------------------------------------------
// Data bytes stream through at one byte per cycle while the 64-byte keystream
// buffer holds bytes and the output is not stalled, passing the s1 and output
// registers. When the buffer is empty, the next data byte waits while a new
// block is made: the working words are loaded, then the 20 rounds run, where
// one shared quarter-round stage does one add-rotate-xor step of all four
// quarter rounds each cycle, then the feed-forward writes one word per cycle
// into the single-port keystream memory. A restart in extended nonce mode
// also runs the HSalsa20 rounds. The block accepts no input beat meanwhile.
`include "salsa20_keystream_cipher_unit_defines.svh"

module salsa20_keystream_cipher_unit
  import sks_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  sks_cfg_if.sink cfg,
  sks_in_if.sink  din,
  sks_out_if.source dout
);

  sks_state_t state, state_next;

  logic [63:0] cfg_reg [8];
  word_t       matrix [16];
  word_t       x [16];
  word16_t     x_next;
  word_t       ks_mem [16];
  word_t       ks_rdata;
  logic [6:0]  bytes_left;
  logic [4:0]  rnd;
  logic [1:0]  step;
  logic [3:0]  feed_cnt;
  logic        hmode;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic [1:0]  s1_lane;
  logic        out_valid;
  logic [7:0]  out_byte;

  logic        advance;
  logic        din_ready;
  logic        gen_start;
  logic        acc_data;
  logic        acc_restart;
  logic        round_last;
  logic [5:0]  pos;

  word8_t      key;
  word16_t     rs_m;
  word16_t     hs_m;
  word16_t     hx_m;

  // Constants and key in place; words 6..9 are taken from lo and hi.
  function automatic word16_t lay_key(input word8_t k, input logic long_form,
                                      input logic [63:0] lo, input logic [63:0] hi);
    word16_t m;
    for (int i = 0; i < 4; i++) begin
      m[1 + i]  = k[i];
      m[11 + i] = long_form ? k[4 + i] : k[i];
    end
    m[0]  = long_form ? SIGMA[0] : TAU[0];
    m[5]  = long_form ? SIGMA[1] : TAU[1];
    m[10] = long_form ? SIGMA[2] : TAU[2];
    m[15] = long_form ? SIGMA[3] : TAU[3];
    m[6]  = lo[31:0];
    m[7]  = lo[63:32];
    m[8]  = hi[31:0];
    m[9]  = hi[63:32];
    return m;
  endfunction

  always_comb begin
    word8_t hk;
    for (int i = 0; i < 4; i++) begin
      key[2 * i]     = cfg_reg[i][31:0];
      key[2 * i + 1] = cfg_reg[i][63:32];
    end
    // The derived key is taken from the words after the final round step.
    hk[0] = x_next[0];
    hk[1] = x_next[5];
    hk[2] = x_next[10];
    hk[3] = x_next[15];
    hk[4] = x_next[6];
    hk[5] = x_next[7];
    hk[6] = x_next[8];
    hk[7] = x_next[9];
    rs_m = lay_key(key, din.long_key, cfg_reg[6], cfg_reg[7]);
    hs_m = lay_key(key, din.long_key, cfg_reg[4], cfg_reg[5]);
    hx_m = lay_key(hk, 1'b1, cfg_reg[6], cfg_reg[7]);
  end

  // One step of all four quarter rounds; their target words never collide.
  always_comb begin
    logic [3:0] t, p, q;
    for (int i = 0; i < 16; i++) x_next[i] = x[i];
    for (int j = 0; j < 4; j++) begin
      t = QIDX[rnd[0]][j][2'(step + 2'd1)];
      p = QIDX[rnd[0]][j][step];
      q = QIDX[rnd[0]][j][2'(step + 2'd3)];
      x_next[t] = x[t] ^ qr_rot(x[p] + x[q], step);
    end
  end

  assign round_last = (rnd == LAST_ROUND) && (step == 2'd3);
  assign advance    = !out_valid || dout.ready;
  assign pos        = 6'(7'd64 - bytes_left);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (gen_start || (acc_restart && din.extended_nonce)) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_last) begin
          state_next = hmode ? ST_RUN : ST_FEED;
        end
      end
      ST_FEED: begin
        if (feed_cnt == 4'd15) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_comb begin
    din_ready = 1'b0;
    gen_start = 1'b0;
    unique case (state)
      ST_RUN: begin
        din_ready = (din.action || bytes_left != 7'd0) && (!s1_valid || advance);
        gen_start = din.valid && !din.action && bytes_left == 7'd0;
      end
      default: begin
        din_ready = 1'b0;
        gen_start = 1'b0;
      end
    endcase
  end

  assign acc_data    = din.valid && din_ready && !din.action;
  assign acc_restart = din.valid && din_ready && din.action;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RUN;
      bytes_left <= 7'd0;
      rnd        <= 5'd0;
      step       <= 2'd0;
      feed_cnt   <= 4'd0;
      hmode      <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 8; i++) cfg_reg[i] <= 64'd0;
      for (int i = 0; i < 16; i++) matrix[i] <= 32'd0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        cfg_reg[cfg.index] <= cfg.data;
      end

      if (gen_start) begin
        for (int i = 0; i < 16; i++) x[i] <= matrix[i];
        hmode <= 1'b0;
        rnd   <= 5'd0;
        step  <= 2'd0;
      end else if (acc_restart) begin
        bytes_left <= 7'd0;
        if (din.extended_nonce) begin
          for (int i = 0; i < 16; i++) x[i] <= hs_m[i];
          hmode <= 1'b1;
          rnd   <= 5'd0;
          step  <= 2'd0;
        end else begin
          for (int i = 0; i < 16; i++) matrix[i] <= rs_m[i];
        end
      end else if (acc_data) begin
        bytes_left <= bytes_left - 7'd1;
      end

      if (state == ST_ROUND) begin
        for (int i = 0; i < 16; i++) x[i] <= x_next[i];
        step <= 2'(step + 2'd1);
        if (step == 2'd3) begin
          rnd <= 5'(rnd + 5'd1);
        end
        feed_cnt <= 4'd0;
        if (round_last && hmode) begin
          for (int i = 0; i < 16; i++) matrix[i] <= hx_m[i];
        end
      end

      if (state == ST_FEED) begin
        feed_cnt <= 4'(feed_cnt + 4'd1);
        if (feed_cnt == 4'd15) begin
          {matrix[9], matrix[8]} <= {matrix[9], matrix[8]} + 64'd1;
          bytes_left <= 7'd64;
        end
      end

      if (acc_data) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Keystream memory: feed-forward writes, one registered read per data beat.
  always_ff @(posedge clk) begin
    if (state == ST_FEED) begin
      ks_mem[feed_cnt] <= x[feed_cnt] + matrix[feed_cnt];
    end
    if (acc_data) begin
      ks_rdata <= ks_mem[pos[5:2]];
      s1_byte  <= din.data_byte;
      s1_lane  <= pos[1:0];
    end
    if (advance) begin
      out_byte <= s1_byte ^ ks_rdata[8 * s1_lane +: 8];
    end
  end

  assign cfg.ready     = 1'b1;
  assign din.ready     = din_ready;
  assign dout.valid    = out_valid;
  assign dout.out_byte = out_byte;

  `SKS_ASSERT_IMP(a_left_range, 1'b1, bytes_left <= 7'd64)
  `SKS_ASSERT_IMP(a_busy_stall, state != ST_RUN, !din.ready)
  `SKS_ASSERT_IMP(a_data_has_ks, din.valid && din.ready && !din.action, bytes_left != 7'd0)
  `SKS_ASSERT_NXT(a_feed_refill, state == ST_FEED && feed_cnt == 4'd15, bytes_left == 7'd64)

endmodule
